/* rtl/core/assert_macros.svh */
// Assertion macros shared by the refraction unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VRU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("refraction unit check failed");

// Next-cycle implication, checked outside reset.
`define VRU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("refraction unit check failed");

`endif

/* rtl/core/vru_pkg.sv */
// Types and constants shared by the refraction unit modules.
`default_nettype none
package vru_pkg;
    localparam int DW = 16;
    localparam int OW = 19;
    localparam int CW = 34;
    localparam int SW = 22;
    localparam int PW = 24;
    localparam int MW = 50;
    localparam int RW = MW / 2;
    localparam int RMW = RW + 2;
    localparam int SQ_STAGES = 5;
    localparam int SQ_STEPS = RW / SQ_STAGES;
    localparam int FRONT_LAT = 8;
    localparam int BACK_LAT = 2;
    localparam int PIPE_LAT = FRONT_LAT + SQ_STAGES + BACK_LAT;

    localparam logic signed [CW-1:0] ONE_COS = CW'(64'sd268435456);
    localparam logic signed [MW:0] ONE_LEN = (MW+1)'(64'sd268435456);
    localparam logic signed [OW-1:0] OUT_MAX = OW'(262143);
    localparam logic signed [OW-1:0] OUT_MIN = OW'(-262144);

    typedef logic signed [DW-1:0] comp_t;
    typedef logic signed [PW-1:0] perp_t;
    typedef logic signed [OW-1:0] res_t;

    typedef struct packed {
        perp_t px;
        perp_t py;
        perp_t pz;
        comp_t nx;
        comp_t ny;
        comp_t nz;
    } side_t;
endpackage
`default_nettype wire

/* rtl/core/vru_front.sv */
// Front pipeline: cosine, perpendicular part and the square-root operand.
`default_nettype none
module vru_front import vru_pkg::*; (
    input  logic               aclk,
    input  logic               ce,
    input  comp_t              dir_i [3],
    input  comp_t              norm_i [3],
    input  logic [DW-1:0]      eta_i,
    output logic [MW-1:0]      m_o,
    output side_t              side_o
);
    comp_t               d1_reg [3], d2_reg [3], d3_reg [3];
    comp_t               n1_reg [3], n2_reg [3], n3_reg [3], n4_reg [3];
    comp_t               n5_reg [3], n6_reg [3], n7_reg [3];
    logic [DW-1:0]       e1_reg, e2_reg, e3_reg, e4_reg;
    logic signed [31:0]  p1_reg [3];
    logic signed [CW-1:0] cos2_reg;
    logic signed [49:0]  t3_reg [3];
    logic signed [SW-1:0] s4_reg [3];
    logic signed [38:0]  q5_reg [3];
    perp_t               p6_reg [3], p7_reg [3];
    logic signed [47:0]  sq7_reg [3];
    logic [MW-1:0]       m8_reg;
    side_t               side8_reg;

    logic signed [CW-1:0] cos_next;
    logic signed [50:0]   s42 [3];
    perp_t                perp_next [3];
    logic signed [39:0]   qr [3];
    logic signed [MW:0]   len2;
    logic signed [MW:0]   diff;

    always_comb begin
        cos_next = -(CW'(p1_reg[0]) + CW'(p1_reg[1]) + CW'(p1_reg[2]));
        if (cos_next > ONE_COS) begin
            cos_next = ONE_COS;
        end
        for (int i = 0; i < 3; i++) begin
            s42[i] = 51'($signed({d3_reg[i], 28'd0})) + 51'(t3_reg[i])
                   + 51'sd134217728;
            qr[i] = 40'(q5_reg[i]) + 40'sd8192;
            perp_next[i] = qr[i][37:14];
        end
        len2 = (MW+1)'(sq7_reg[0]) + (MW+1)'(sq7_reg[1]) + (MW+1)'(sq7_reg[2]);
        diff = ONE_LEN - len2;
        if (diff < 0) begin
            diff = -diff;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                d1_reg[i]  <= dir_i[i];
                n1_reg[i]  <= norm_i[i];
                p1_reg[i]  <= dir_i[i] * norm_i[i];
                d2_reg[i]  <= d1_reg[i];
                n2_reg[i]  <= n1_reg[i];
                d3_reg[i]  <= d2_reg[i];
                n3_reg[i]  <= n2_reg[i];
                t3_reg[i]  <= cos2_reg * n2_reg[i];
                n4_reg[i]  <= n3_reg[i];
                s4_reg[i]  <= s42[i][49:28];
                n5_reg[i]  <= n4_reg[i];
                q5_reg[i]  <= $signed({1'b0, e4_reg}) * s4_reg[i];
                n6_reg[i]  <= n5_reg[i];
                p6_reg[i]  <= perp_next[i];
                n7_reg[i]  <= n6_reg[i];
                p7_reg[i]  <= p6_reg[i];
                sq7_reg[i] <= p6_reg[i] * p6_reg[i];
            end
            e1_reg    <= eta_i;
            e2_reg    <= e1_reg;
            e3_reg    <= e2_reg;
            e4_reg    <= e3_reg;
            cos2_reg  <= cos_next;
            m8_reg    <= diff[MW-1:0];
            side8_reg <= '{px: p7_reg[0], py: p7_reg[1], pz: p7_reg[2],
                           nx: n7_reg[0], ny: n7_reg[1], nz: n7_reg[2]};
        end
    end

    assign m_o    = m8_reg;
    assign side_o = side8_reg;
endmodule
`default_nettype wire

/* rtl/core/vru_sqrt.sv */
// Pipelined digit-by-digit integer square root, several bits per stage.
`default_nettype none
module vru_sqrt import vru_pkg::*; (
    input  logic          aclk,
    input  logic          ce,
    input  logic [MW-1:0] m_i,
    input  side_t         side_i,
    output logic [RW-1:0] root_o,
    output side_t         side_o
);
    logic [RMW-1:0] rem_reg  [SQ_STAGES];
    logic [RW-1:0]  root_reg [SQ_STAGES];
    logic [MW-1:0]  val_reg  [SQ_STAGES];
    side_t          side_reg [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        logic [RMW-1:0] rem_in, rem_c, trial;
        logic [RW-1:0]  root_in, root_c;
        logic [MW-1:0]  val_in, val_c;
        side_t          side_in;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign val_in  = m_i;
            assign side_in = side_i;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign val_in  = val_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb begin
            rem_c  = rem_in;
            root_c = root_in;
            val_c  = val_in;
            trial  = '0;
            for (int j = 0; j < SQ_STEPS; j++) begin
                rem_c = {rem_c[RMW-3:0], val_c[MW-1:MW-2]};
                val_c = {val_c[MW-3:0], 2'b00};
                trial = {root_c, 2'b01};
                if (rem_c >= trial) begin
                    rem_c  = rem_c - trial;
                    root_c = {root_c[RW-2:0], 1'b1};
                end else begin
                    root_c = {root_c[RW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k]  <= rem_c;
                root_reg[k] <= root_c;
                val_reg[k]  <= val_c;
                side_reg[k] <= side_in;
            end
        end
    end

    assign root_o = root_reg[SQ_STAGES-1];
    assign side_o = side_reg[SQ_STAGES-1];
endmodule
`default_nettype wire

/* rtl/core/vru_back.sv */
// Back pipeline: parallel part, final sum and output saturation.
`default_nettype none
module vru_back import vru_pkg::*; (
    input  logic          aclk,
    input  logic          ce,
    input  logic [RW-1:0] root_i,
    input  side_t         side_i,
    output res_t          out_o [3]
);
    logic signed [41:0] prod_reg [3];
    perp_t              perp_reg [3];
    res_t               out_reg  [3];

    comp_t              nv [3];
    perp_t              pv [3];
    logic signed [42:0] par [3];
    logic signed [42:0] sum [3];

    always_comb begin
        nv = '{side_i.nx, side_i.ny, side_i.nz};
        pv = '{side_i.px, side_i.py, side_i.pz};
        for (int i = 0; i < 3; i++) begin
            par[i] = (-43'(prod_reg[i]) + 43'sd8192) >>> 14;
            sum[i] = 43'(perp_reg[i]) + par[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= $signed({1'b0, root_i}) * nv[i];
                perp_reg[i] <= pv[i];
                if (sum[i] > 43'(OUT_MAX)) begin
                    out_reg[i] <= OUT_MAX;
                end else if (sum[i] < 43'(OUT_MIN)) begin
                    out_reg[i] <= OUT_MIN;
                end else begin
                    out_reg[i] <= sum[i][OW-1:0];
                end
            end
        end
    end

    assign out_o = out_reg;
endmodule
`default_nettype wire

/* rtl/core/vector_refraction_unit.sv */
// Top level of the fixed-point vector refraction unit.
// The unit takes one beat per cycle while the output is not stalled and passes each
// accepted beat through eight front stages that form the cosine, the perpendicular
// part and the square-root operand, five stages that resolve the 25-bit square root
// five bits at a time, and two stages that form the parallel part and saturate the sum.
// The whole pipeline holds while a finished result waits on m_ready.
`default_nettype none
`include "assert_macros.svh"
module vector_refraction_unit import vru_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [15:0]   s_dir_x,
    input  logic signed [15:0]   s_dir_y,
    input  logic signed [15:0]   s_dir_z,
    input  logic signed [15:0]   s_norm_x,
    input  logic signed [15:0]   s_norm_y,
    input  logic signed [15:0]   s_norm_z,
    input  logic [15:0]          s_index_ratio,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [18:0]   m_out_x,
    output logic signed [18:0]   m_out_y,
    output logic signed [18:0]   m_out_z
);
    logic [PIPE_LAT-1:0] vld_reg, vld_next;
    logic                ce;
    comp_t               dir_v [3];
    comp_t               norm_v [3];
    logic [MW-1:0]       m_val;
    side_t               side_f, side_s;
    logic [RW-1:0]       root;
    res_t                res [3];

    assign ce      = m_ready || !vld_reg[PIPE_LAT-1];
    assign s_ready = ce;
    assign m_valid = vld_reg[PIPE_LAT-1];

    assign dir_v  = '{s_dir_x, s_dir_y, s_dir_z};
    assign norm_v = '{s_norm_x, s_norm_y, s_norm_z};

    always_comb begin
        vld_next = vld_reg;
        if (ce) begin
            vld_next = {vld_reg[PIPE_LAT-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    vru_front u_front (
        .aclk   (aclk),
        .ce     (ce),
        .dir_i  (dir_v),
        .norm_i (norm_v),
        .eta_i  (s_index_ratio),
        .m_o    (m_val),
        .side_o (side_f)
    );

    vru_sqrt u_sqrt (
        .aclk   (aclk),
        .ce     (ce),
        .m_i    (m_val),
        .side_i (side_f),
        .root_o (root),
        .side_o (side_s)
    );

    vru_back u_back (
        .aclk   (aclk),
        .ce     (ce),
        .root_i (root),
        .side_i (side_s),
        .out_o  (res)
    );

    assign m_out_x = res[0];
    assign m_out_y = res[1];
    assign m_out_z = res[2];

    `VRU_ASSERT_NEXT(a_stall_holds_pipe, !ce, $stable(vld_reg))
    `VRU_ASSERT_NEXT(a_beat_reaches_out, ce && vld_reg[PIPE_LAT-2], m_valid)
    `VRU_ASSERT_NOW(a_ready_when_empty, !m_valid, s_ready)
endmodule
`default_nettype wire

/* sim/vector_refraction_unit_test.sv */
// Self-checking testbench for the vector refraction unit against a bit-exact predictor.
`timescale 1ns / 100ps
`default_nettype none
module vector_refraction_unit_test;
    import vru_pkg::*;

    typedef struct {
        logic signed [18:0] x;
        logic signed [18:0] y;
        logic signed [18:0] z;
    } ray_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_dir_x = '0, s_dir_y = '0, s_dir_z = '0;
    logic signed [15:0] s_norm_x = '0, s_norm_y = '0, s_norm_z = '0;
    logic [15:0] s_index_ratio = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [18:0] m_out_x, m_out_y, m_out_z;

    ray_t refracted_q[$];
    int error_count = 0;
    int idle_cycles = 0;
    int hold_off = 0;
    int burst_left = 0;
    bit pace_sender = 1'b1;
    bit stall_enable = 1'b1;

    vector_refraction_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_dir_x(s_dir_x), .s_dir_y(s_dir_y), .s_dir_z(s_dir_z),
        .s_norm_x(s_norm_x), .s_norm_y(s_norm_y), .s_norm_z(s_norm_z),
        .s_index_ratio(s_index_ratio),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_x(m_out_x), .m_out_y(m_out_y), .m_out_z(m_out_z)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint round_q(longint v, int k);
        return (v + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function automatic longint floor_root(longint v);
        longint r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            if ((r | (longint'(1) << b)) * (r | (longint'(1) << b)) <= v) begin
                r = r | (longint'(1) << b);
            end
        end
        return r;
    endfunction

    function automatic logic signed [18:0] clamp_out(longint v);
        if (v > 262143) begin
            return 19'sd262143;
        end
        if (v < -262144) begin
            return -19'sd262144;
        end
        return v[18:0];
    endfunction

    function automatic ray_t refract(logic signed [15:0] d[3], logic signed [15:0] n[3],
                                     logic [15:0] eta);
        longint cosv, len2, mag, root, s14;
        longint perp[3];
        longint res[3];
        ray_t r;
        cosv = 0;
        len2 = 0;
        for (int i = 0; i < 3; i++) begin
            cosv -= longint'(d[i]) * longint'(n[i]);
        end
        if (cosv > (longint'(1) << 28)) begin
            cosv = longint'(1) << 28;
        end
        for (int i = 0; i < 3; i++) begin
            s14 = round_q(longint'(d[i]) * (longint'(1) << 28) + cosv * longint'(n[i]), 28);
            perp[i] = round_q(longint'(eta) * s14, 14);
            len2 += perp[i] * perp[i];
        end
        mag = (longint'(1) << 28) - len2;
        if (mag < 0) begin
            mag = -mag;
        end
        root = floor_root(mag);
        for (int i = 0; i < 3; i++) begin
            res[i] = perp[i] + round_q(-(root * longint'(n[i])), 14);
        end
        r.x = clamp_out(res[0]);
        r.y = clamp_out(res[1]);
        r.z = clamp_out(res[2]);
        return r;
    endfunction

    task automatic send_ray(logic signed [15:0] d[3], logic signed [15:0] n[3],
                            logic [15:0] eta);
        int gap;
        if (pace_sender && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_valid <= 1'b1;
        s_dir_x <= d[0];
        s_dir_y <= d[1];
        s_dir_z <= d[2];
        s_norm_x <= n[0];
        s_norm_y <= n[1];
        s_norm_z <= n[2];
        s_index_ratio <= eta;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        refracted_q.push_back(refract(d, n, eta));
        if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (refracted_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh4000;
            3: return -16'sh4000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic signed [15:0] d[3], n[3];
        logic [15:0] ratios[5] = '{16'h0000, 16'h4000, 16'hFFFF, 16'h3000, 16'h5555};
        foreach (ratios[k]) begin
            d = '{16'sh0000, -16'sh4000, 16'sh0000};
            n = '{16'sh0000, 16'sh4000, 16'sh0000};
            send_ray(d, n, ratios[k]);
        end
        d = '{16'sh2D41, -16'sh2D41, 16'sh0000};
        n = '{16'sh0000, 16'sh4000, 16'sh0000};
        send_ray(d, n, 16'h8000);
        send_ray(d, n, 16'hFFFF);
        d = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
        n = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
        send_ray(d, n, 16'hFFFF);
        d = '{16'sh8000, 16'sh8000, 16'sh8000};
        send_ray(d, n, 16'hFFFF);
        n = '{16'sh8000, 16'sh8000, 16'sh8000};
        send_ray(d, n, 16'hFFFF);
        send_ray(d, n, 16'h0000);
        d = '{16'sh7FFF, 16'sh8000, 16'sh7FFF};
        n = '{16'sh8000, 16'sh7FFF, 16'sh8000};
        send_ray(d, n, 16'hFFFF);
        d = '{16'sh0000, 16'sh0000, 16'sh0000};
        n = '{16'sh0000, 16'sh0000, 16'sh0000};
        send_ray(d, n, 16'h4000);
        d = '{16'sh4000, 16'sh0000, 16'sh0000};
        send_ray(d, n, 16'hFFFF);
        drain();
    endtask

    task automatic test_random(int count);
        logic signed [15:0] d[3], n[3];
        logic [15:0] eta;
        for (int i = 0; i < count; i++) begin
            foreach (d[k]) begin
                d[k] = ($urandom_range(0, 3) == 0) ? rand_comp()
                                                   : 16'(int'($urandom_range(0, 32768)) - 16384);
                n[k] = ($urandom_range(0, 3) == 0) ? rand_comp()
                                                   : 16'(int'($urandom_range(0, 32768)) - 16384);
            end
            eta = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                              : 16'($urandom_range(8192, 32768));
            send_ray(d, n, eta);
        end
    endtask

    task automatic test_back_pressure();
        hold_off = 120;
        pace_sender = 1'b0;
        test_random(40);
        pace_sender = 1'b1;
        drain();
    endtask

    task automatic test_full_rate();
        pace_sender = 1'b0;
        stall_enable = 1'b0;
        test_random(60);
        drain();
        pace_sender = 1'b1;
        stall_enable = 1'b1;
    endtask

    always @(posedge aclk) begin
        if (hold_off > 0) begin
            m_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else if (!stall_enable) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= (($time / 70) % 4 == 3) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        ray_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (refracted_q.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time,
                         m_out_x, m_out_y, m_out_z);
                error_count++;
            end else begin
                exp_r = refracted_q.pop_front();
                if (m_out_x !== exp_r.x) begin
                    $display("%0t: out_x expected %0d actual %0d", $time, exp_r.x, m_out_x);
                    error_count++;
                end
                if (m_out_y !== exp_r.y) begin
                    $display("%0t: out_y expected %0d actual %0d", $time, exp_r.y, m_out_y);
                    error_count++;
                end
                if (m_out_z !== exp_r.z) begin
                    $display("%0t: out_z expected %0d actual %0d", $time, exp_r.z, m_out_z);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > 2000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_back_pressure();
        test_random(436);
        drain();
        test_full_rate();
        repeat (40) @(posedge aclk);
        if (error_count == 0 && refracted_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
